### sv/mkd_pkg.sv
`timescale 1ns / 1ps

package mkd_pkg;

  // Register map of the configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LETTER_GAP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAUSE      = 2'd2;

  localparam logic [CFG_DATA_W-1:0] LONG_PRESS_RESET = 16'd300;
  localparam logic [CFG_DATA_W-1:0] LETTER_GAP_RESET = 16'd1000;
  localparam logic [CFG_DATA_W-1:0] PAUSE_RESET      = 16'd300;

  localparam int unsigned CODE_W    = 6;
  localparam int unsigned PATTERN_W = 5;
  localparam int unsigned IN_W      = 8;
  localparam int unsigned OUT_W     = 80;

  // Index is a leading one followed by the pattern, first symbol in the
  // highest bit, dash = 1. Zero means no letter.
  localparam logic [CODE_W-1:0] CODE_TABLE [32] = '{
    6'h00, 6'h00, 6'h05, 6'h20, 6'h09, 6'h01, 6'h14, 6'h13,
    6'h19, 6'h21, 6'h18, 6'h23, 6'h04, 6'h11, 6'h07, 6'h15,
    6'h08, 6'h22, 6'h06, 6'h00, 6'h12, 6'h00, 6'h16, 6'h10,
    6'h02, 6'h24, 6'h03, 6'h25, 6'h26, 6'h17, 6'h00, 6'h00
  };

  typedef struct packed {
    logic              pad;
    logic [63:0]       message_bytes;
    logic              pausing;
    logic              long_reached;
    logic [2:0]        symbols_held;
    logic [2:0]        cursor;
    logic [CODE_W-1:0] letter_code;
    logic              letter_valid;
  } out_word_t;

endpackage

### sv/morse_key_decoder_unit.sv
`timescale 1ns / 1ps

// Morse key decoder. Each input word is one millisecond tick carrying the key
// level and the delete, space and clear buttons. The block times presses and
// gaps, collects dots and dashes, decodes a letter once the gap reaches the
// letter threshold and keeps an editable message of MESSAGE_SLOTS letters.
// Input stream: one word per tick. Output stream: one result word per tick
// with the decoded letter, cursor, symbol count, press and gap indicators and
// the packed message.
// The result of a tick is loaded into the output register at the edge that
// accepts the tick and can be taken from the next cycle on. A tick can be
// accepted every cycle while the receiver takes each result; the state update
// and the result are computed combinationally.
// When the receiver stalls, the result holds in the output register and the
// input stays ready only if that result is taken in the same cycle.
// The configuration port writes thresholds at once; write it only while no
// tick is in flight. Reset empties the message, symbols, timers and output,
// and loads the default thresholds (300, 1000, 300 ticks).
module morse_key_decoder_unit
  import mkd_pkg::*;
#(
  parameter int unsigned MESSAGE_SLOTS = 8,
  parameter int unsigned MAX_SYMBOLS   = 6,
  parameter int unsigned TIMER_BITS    = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // key_down, delete_pulse, space_pulse, clear_pulse, then zero padding
  input  logic [IN_W-1:0]       s_axis_tdata_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // letter_valid, letter_code[6], cursor[3], symbols_held[3], long_reached,
  // pausing, message_bytes[64], then zero padding
  output logic [OUT_W-1:0]      m_axis_tdata_o
);

  localparam int unsigned CNT_W = $clog2(MAX_SYMBOLS);
  localparam int unsigned CUR_W = $clog2(MESSAGE_SLOTS);
  localparam int unsigned CMP_W = (TIMER_BITS > CFG_DATA_W) ? TIMER_BITS : CFG_DATA_W;

  logic [CFG_DATA_W-1:0] long_cfg_q, gap_cfg_q, pause_cfg_q;

  logic [TIMER_BITS-1:0]  press_q, press_d, gap_q, gap_d;
  logic [MAX_SYMBOLS-1:0] sym_q, sym_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [CUR_W-1:0]       cur_q, cur_d;
  logic [CODE_W-1:0]      msg_q [MESSAGE_SLOTS];
  logic [CODE_W-1:0]      msg_d [MESSAGE_SLOTS];

  out_word_t out_q, out_d;
  logic      out_valid_q;

  logic              accept;
  logic              key, del, spc, clr;
  logic              long_hit, letter_due, pause_hit;
  logic [CODE_W-1:0] lookup_code;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign key = s_axis_tdata_i[0];
  assign del = s_axis_tdata_i[1];
  assign spc = s_axis_tdata_i[2];
  assign clr = s_axis_tdata_i[3];

  assign long_hit   = CMP_W'(press_q) >= CMP_W'(long_cfg_q);
  assign letter_due = CMP_W'(gap_q) >= CMP_W'(gap_cfg_q);
  assign pause_hit  = (CMP_W'(gap_q) >= CMP_W'(pause_cfg_q)) && !key;

  mkd_pattern_decode #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .CNT_W       (CNT_W)
  ) u_pattern_decode (
    .symbols_i (sym_q),
    .count_i   (cnt_q),
    .code_o    (lookup_code)
  );

  always_comb begin
    logic [CODE_W-1:0] dec_code;
    logic [63:0]       packed_msg;
    dec_code = '0;
    press_d  = press_q;
    gap_d    = gap_q;
    sym_d    = sym_q;
    cnt_d    = cnt_q;
    cur_d    = cur_q;
    msg_d    = msg_q;

    // The lookup yields zero for unknown patterns and for counts outside one to four.
    if (letter_due) begin
      if (lookup_code != '0) begin
        dec_code     = lookup_code;
        msg_d[cur_d] = lookup_code;
        cur_d        = (cur_d == CUR_W'(MESSAGE_SLOTS - 1)) ? '0 : cur_d + CUR_W'(1);
      end
      cnt_d = '0;
    end

    if (key) begin
      gap_d = '0;
      if (press_q != '1) begin
        press_d = press_q + TIMER_BITS'(1);
      end
    end else begin
      if (gap_q != '1) begin
        gap_d = gap_q + TIMER_BITS'(1);
      end
      if (press_q != '0) begin
        sym_d[cnt_d] = long_hit;
        cnt_d        = (cnt_d == CNT_W'(MAX_SYMBOLS - 1)) ? '0 : cnt_d + CNT_W'(1);
      end
      press_d = '0;
    end

    if (del) begin
      cur_d        = (cur_d == '0) ? CUR_W'(MESSAGE_SLOTS - 1) : cur_d - CUR_W'(1);
      msg_d[cur_d] = '0;
    end
    if (spc) begin
      msg_d[cur_d] = '0;
      cur_d        = (cur_d == CUR_W'(MESSAGE_SLOTS - 1)) ? '0 : cur_d + CUR_W'(1);
    end
    if (clr) begin
      for (int i = 0; i < MESSAGE_SLOTS; i++) begin
        msg_d[i] = '0;
      end
      cnt_d = '0;
      cur_d = '0;
    end

    packed_msg = '0;
    for (int i = 0; i < MESSAGE_SLOTS; i++) begin
      packed_msg[8*i +: 8] = {2'b00, msg_d[i]};
    end

    out_d.pad           = 1'b0;
    out_d.message_bytes = packed_msg;
    out_d.pausing       = pause_hit;
    out_d.long_reached  = long_hit;
    out_d.symbols_held  = 3'(cnt_d);
    out_d.cursor        = 3'(cur_d);
    out_d.letter_code   = dec_code;
    out_d.letter_valid  = (dec_code != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_cfg_q  <= LONG_PRESS_RESET;
      gap_cfg_q   <= LETTER_GAP_RESET;
      pause_cfg_q <= PAUSE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LONG_PRESS: long_cfg_q  <= cfg_wdata_i;
        REG_LETTER_GAP: gap_cfg_q   <= cfg_wdata_i;
        REG_PAUSE:      pause_cfg_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_q <= '0;
      gap_q   <= '0;
      sym_q   <= '0;
      cnt_q   <= '0;
      cur_q   <= '0;
      for (int i = 0; i < MESSAGE_SLOTS; i++) begin
        msg_q[i] <= '0;
      end
    end else if (accept) begin
      press_q <= press_d;
      gap_q   <= gap_d;
      sym_q   <= sym_d;
      cnt_q   <= cnt_d;
      cur_q   <= cur_d;
      msg_q   <= msg_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

endmodule

### sv/mkd_pattern_decode.sv
`timescale 1ns / 1ps

module mkd_pattern_decode
  import mkd_pkg::*;
#(
  parameter int unsigned MAX_SYMBOLS = 6,
  parameter int unsigned CNT_W       = 3
) (
  input  logic [MAX_SYMBOLS-1:0] symbols_i,
  input  logic [CNT_W-1:0]       count_i,
  output logic [CODE_W-1:0]      code_o
);

  logic [PATTERN_W-1:0] idx;

  // Patterns of zero or more than four symbols map to index 0, which holds no letter.
  always_comb begin
    case (count_i)
      CNT_W'(1): idx = {3'b000, 1'b1, symbols_i[0]};
      CNT_W'(2): idx = {2'b00, 1'b1, symbols_i[0], symbols_i[1]};
      CNT_W'(3): idx = {1'b0, 1'b1, symbols_i[0], symbols_i[1], symbols_i[2]};
      CNT_W'(4): idx = {1'b1, symbols_i[0], symbols_i[1], symbols_i[2], symbols_i[3]};
      default:   idx = '0;
    endcase
  end

  assign code_o = CODE_TABLE[idx];

endmodule
